@@ rtl/cps_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants of the counter priority scheduler.
// No dependencies; used by cps_scan and counter_priority_scheduler_unit.
package cps_pkg;

    localparam int NUM_PROCS  = 32;
    localparam int IDX_W      = $clog2(NUM_PROCS);
    localparam int CNT_W      = 8;
    localparam int TIME_W     = 32;
    localparam int MASK_W     = 32;
    localparam int PIDX_W     = 5;
    localparam int IN_DATA_W  = 88;
    localparam int OUT_DATA_W = 40;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_PROCS - 1);
    localparam logic [PIDX_W:0]  PROC_LIMIT = (PIDX_W + 1)'(NUM_PROCS);

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_SCHED = 1'b1;

    typedef struct packed {
        logic              ready;
        logic [CNT_W-1:0]  counter;
        logic [CNT_W-1:0]  prio;
        logic [TIME_W-1:0] alarm;
    } entry_t;

    typedef struct packed {
        logic             clear_all;
        logic             clear_best;
        logic             step;
        logic             reload;
        logic [IDX_W-1:0] idx;
    } scan_ctrl_t;

endpackage

@@ rtl/cps_ram.sv @@
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module cps_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ rtl/cps_scan.sv @@
`timescale 1ns / 1ps
// Per-entry scan datapath: alarm firing, counter reload and best-entry search.
// Depends on cps_pkg.
module cps_scan (
    input  logic                             clk,
    input  logic                             rst_n,
    input  cps_pkg::scan_ctrl_t              ctrl,
    input  cps_pkg::entry_t                  entry,
    input  logic [cps_pkg::TIME_W-1:0]       now,
    output logic                             wb_en,
    output cps_pkg::entry_t                  wb_entry,
    output logic                             found,
    output logic [cps_pkg::IDX_W-1:0]        best_idx,
    output logic [cps_pkg::NUM_PROCS-1:0]    mask
);

    logic [cps_pkg::CNT_W-1:0]     best_cnt_reg, best_cnt_next;
    logic [cps_pkg::IDX_W-1:0]     best_idx_reg, best_idx_next;
    logic [cps_pkg::NUM_PROCS-1:0] mask_reg, mask_next;
    logic                          fire;
    logic                          better;
    logic [cps_pkg::CNT_W-1:0]     cand;

    always_comb
    begin
        fire   = ctrl.step && !ctrl.reload && (entry.alarm != '0) && (entry.alarm < now);
        cand   = (ctrl.reload && entry.ready) ? entry.prio : entry.counter;
        better = ctrl.step && entry.ready && (cand > best_cnt_reg);

        wb_entry         = entry;
        wb_entry.counter = cand;
        if (fire)
        begin
            wb_entry.alarm = '0;
        end
        wb_en = ctrl.step && (fire || (ctrl.reload && entry.ready));

        mask_next = mask_reg;
        if (ctrl.clear_all)
        begin
            mask_next = '0;
        end
        else if (fire)
        begin
            mask_next[ctrl.idx] = 1'b1;
        end

        best_cnt_next = best_cnt_reg;
        best_idx_next = best_idx_reg;
        if (ctrl.clear_best)
        begin
            best_cnt_next = '0;
            best_idx_next = '0;
        end
        else if (better)
        begin
            // strict compare keeps the lowest index on ties
            best_cnt_next = cand;
            best_idx_next = ctrl.idx;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            best_cnt_reg <= '0;
            best_idx_reg <= '0;
            mask_reg     <= '0;
        end
        else
        begin
            best_cnt_reg <= best_cnt_next;
            best_idx_reg <= best_idx_next;
            mask_reg     <= mask_next;
        end
    end

    assign found    = (best_cnt_reg != '0);
    assign best_idx = best_idx_reg;
    assign mask     = mask_reg;

endmodule

@@ rtl/counter_priority_scheduler_unit.sv @@
`timescale 1ns / 1ps
// Top level of the counter priority scheduler: handshake, sequencer, entry table.
// Depends on cps_pkg, cps_ram and cps_scan.
//
// The process table sits in one RAM, one entry per word, with a valid bit per
// entry so that entries never written read as zero. A write transfer stores a
// whole entry in the cycle it is accepted, then passes through the finish state and
// yields an all-zero result once the output register is free.
// A schedule transfer walks the table through the RAM read
// port, one entry per cycle: the first pass fires and clears expired alarms
// while searching for the ready entry with the largest counter; if none is
// found a second pass reloads ready counters from their priorities and
// searches again. The input is taken again as soon as the result is in the
// output register.
module counter_priority_scheduler_unit (
    input  logic                               clk,
    input  logic                               rst_n,
    // s_tdata: proc_index[4:0], ready_req[5], counter_value[13:6],
    //          priority_value[21:14], alarm_time[53:22], current_time[85:54], zero pad
    input  logic [cps_pkg::IN_DATA_W-1:0]      s_tdata,
    // s_tuser: operation
    input  logic                               s_tuser,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // m_tdata: chosen_proc[4:0], found[5], alarm_mask[37:6], reloaded[38], zero pad
    output logic [cps_pkg::OUT_DATA_W-1:0]     m_tdata,
    output logic                               m_tvalid,
    input  logic                               m_tready
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_CHECK,
        ST_FINISH
    } state_t;

    state_t                          state_reg, state_next;
    logic [cps_pkg::IDX_W-1:0]       issue_idx_reg, issue_idx_next;
    logic                            issue_done_reg, issue_done_next;
    logic                            rd_vld_reg, rd_vld_next;
    logic [cps_pkg::IDX_W-1:0]       proc_idx_reg, proc_idx_next;
    logic                            reload_reg, reload_next;
    logic                            sched_reg, sched_next;
    logic [cps_pkg::TIME_W-1:0]      now_reg, now_next;
    logic [cps_pkg::NUM_PROCS-1:0]   valid_reg, valid_next;
    logic                            vld_q_reg, vld_q_next;
    logic                            m_tvalid_reg, m_tvalid_next;
    logic [cps_pkg::OUT_DATA_W-1:0]  m_tdata_reg, m_tdata_next;

    logic [cps_pkg::PIDX_W-1:0]      in_proc_index;
    cps_pkg::entry_t                 in_entry;
    logic [cps_pkg::TIME_W-1:0]      in_current_time;
    logic                            in_xfer;
    logic                            in_wr;
    logic                            rd_en;
    logic                            ram_wr_en;
    logic [cps_pkg::IDX_W-1:0]       ram_wr_addr;
    cps_pkg::entry_t                 ram_wr_data;
    cps_pkg::entry_t                 ram_q;
    cps_pkg::entry_t                 cur_entry;
    cps_pkg::scan_ctrl_t             scan_ctrl;
    logic                            wb_en;
    cps_pkg::entry_t                 wb_entry;
    logic                            found;
    logic [cps_pkg::IDX_W-1:0]       best_idx;
    logic [cps_pkg::NUM_PROCS-1:0]   mask;
    logic                            pass_end;
    logic                            need_reload;
    logic                            out_free;
    logic [cps_pkg::OUT_DATA_W-1:0]  res_data;

    assign in_proc_index    = s_tdata[4:0];
    assign in_entry.ready   = s_tdata[5];
    assign in_entry.counter = s_tdata[13:6];
    assign in_entry.prio    = s_tdata[21:14];
    assign in_entry.alarm   = s_tdata[53:22];
    assign in_current_time  = s_tdata[85:54];

    assign s_tready = (state_reg == ST_IDLE);
    assign in_xfer  = s_tvalid && s_tready;
    assign in_wr    = in_xfer && (s_tuser == cps_pkg::OP_WRITE)
                      && ({1'b0, in_proc_index} < cps_pkg::PROC_LIMIT);

    assign rd_en     = (state_reg == ST_SCAN) && !issue_done_reg;
    assign cur_entry = vld_q_reg ? ram_q : '0;
    assign pass_end  = rd_vld_reg && (proc_idx_reg == cps_pkg::LAST_IDX);
    assign need_reload = !reload_reg && !found;
    assign out_free  = !m_tvalid_reg || m_tready;

    // host writes only happen in idle, scan write-backs only during a pass
    assign ram_wr_en   = in_wr || wb_en;
    assign ram_wr_addr = in_wr ? in_proc_index[cps_pkg::IDX_W-1:0] : proc_idx_reg;
    assign ram_wr_data = in_wr ? in_entry : wb_entry;

    always_comb
    begin
        scan_ctrl.clear_all  = in_xfer;
        scan_ctrl.clear_best = in_xfer || ((state_reg == ST_CHECK) && need_reload);
        scan_ctrl.step       = rd_vld_reg;
        scan_ctrl.reload     = reload_reg;
        scan_ctrl.idx        = proc_idx_reg;
    end

    cps_ram #(
        .WIDTH ($bits(cps_pkg::entry_t)),
        .DEPTH (cps_pkg::NUM_PROCS)
    ) u_table (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (rd_en),
        .rd_addr (issue_idx_reg),
        .rd_data (ram_q)
    );

    cps_scan u_scan (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (scan_ctrl),
        .entry    (cur_entry),
        .now      (now_reg),
        .wb_en    (wb_en),
        .wb_entry (wb_entry),
        .found    (found),
        .best_idx (best_idx),
        .mask     (mask)
    );

    always_comb
    begin
        res_data = '0;
        if (sched_reg)
        begin
            res_data[4:0]  = found ? cps_pkg::PIDX_W'(best_idx) : '0;
            res_data[5]    = found;
            res_data[37:6] = cps_pkg::MASK_W'(mask);
            res_data[38]   = reload_reg;
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        issue_idx_next  = issue_idx_reg;
        issue_done_next = issue_done_reg;
        rd_vld_next     = rd_en;
        proc_idx_next   = rd_en ? issue_idx_reg : proc_idx_reg;
        reload_next     = reload_reg;
        sched_next      = sched_reg;
        now_next        = now_reg;
        valid_next      = valid_reg;
        vld_q_next      = rd_en ? valid_reg[issue_idx_reg] : vld_q_reg;
        m_tvalid_next   = m_tvalid_reg;
        m_tdata_next    = m_tdata_reg;

        if (in_wr)
        begin
            valid_next[in_proc_index[cps_pkg::IDX_W-1:0]] = 1'b1;
        end

        if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    sched_next      = s_tuser;
                    now_next        = in_current_time;
                    reload_next     = 1'b0;
                    issue_idx_next  = '0;
                    issue_done_next = 1'b0;
                    state_next      = (s_tuser == cps_pkg::OP_SCHED) ? ST_SCAN : ST_FINISH;
                end
            end
            ST_SCAN:
            begin
                if (rd_en)
                begin
                    if (issue_idx_reg == cps_pkg::LAST_IDX)
                    begin
                        issue_done_next = 1'b1;
                    end
                    else
                    begin
                        issue_idx_next = issue_idx_reg + 1'b1;
                    end
                end
                if (pass_end)
                begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (need_reload)
                begin
                    reload_next     = 1'b1;
                    issue_idx_next  = '0;
                    issue_done_next = 1'b0;
                    state_next      = ST_SCAN;
                end
                else
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = res_data;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            issue_idx_reg  <= '0;
            issue_done_reg <= 1'b1;
            rd_vld_reg     <= 1'b0;
            proc_idx_reg   <= '0;
            reload_reg     <= 1'b0;
            sched_reg      <= 1'b0;
            valid_reg      <= '0;
            vld_q_reg      <= 1'b0;
            m_tvalid_reg   <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            issue_idx_reg  <= issue_idx_next;
            issue_done_reg <= issue_done_next;
            rd_vld_reg     <= rd_vld_next;
            proc_idx_reg   <= proc_idx_next;
            reload_reg     <= reload_next;
            sched_reg      <= sched_next;
            valid_reg      <= valid_next;
            vld_q_reg      <= vld_q_next;
            m_tvalid_reg   <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        now_reg     <= now_next;
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // a host write and a scan write-back must never compete for the write port
    a_wr_port_free: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_wr && wb_en))
        else $error("host write collides with scan write-back");

    // no choice means the chosen index reads zero
    a_no_choice_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tdata[5]) |-> (m_tdata[4:0] == '0))
        else $error("chosen_proc nonzero without a choice");

    // a finished result waits rather than overwrite a pending transfer
    a_finish_waits: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FINISH && m_tvalid_reg && !m_tready)
        |=> (state_reg == ST_FINISH && m_tvalid && $stable(m_tdata)))
        else $error("pending result overwritten");

    // a result with neither a choice nor a reload comes from a write and is all zero
    a_found_or_reloaded: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tdata[5] && !m_tdata[38]) |-> (m_tdata == '0))
        else $error("empty choice reported without reload");

endmodule
